// ===== design/touch_report_parser_defines.svh =====
// assertion macros for the touch report parser checker
// no dependencies; included by the checker file only
`ifndef TOUCH_REPORT_PARSER_DEFINES_SVH
`define TOUCH_REPORT_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TRP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch report parser check failed");

// next-cycle implication, disabled during reset
`define TRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch report parser check failed");

// check with no reset disable
`define TRP_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("touch report parser check failed");

`endif

// ===== design/trp_pkg.sv =====
// shared types and constants for the touch report parser
// no dependencies; imported by every module of the block
package trp_pkg;

  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 12;
  localparam int SCALE_W    = 16;
  localparam int PROD_W     = COORD_W + SCALE_W;
  localparam int LOW_W      = 7;
  localparam int HIGH_W     = COORD_W - LOW_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // header bytes
  localparam logic [BYTE_W-1:0] HDR_PRESS   = 8'h81;
  localparam logic [BYTE_W-1:0] HDR_RELEASE = 8'h80;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RECIP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RECIP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT  = 3'd5;

  // register reset values
  localparam logic [COORD_W-1:0] RST_X_OFFSET = 12'd108;
  localparam logic [COORD_W-1:0] RST_Y_OFFSET = 12'd260;
  localparam logic [SCALE_W-1:0] RST_X_RECIP  = 16'd13378;
  localparam logic [SCALE_W-1:0] RST_Y_RECIP  = 16'd8357;
  localparam logic [COORD_W-1:0] RST_X_LIMIT  = 12'd800;
  localparam logic [COORD_W-1:0] RST_Y_LIMIT  = 12'd480;

  typedef struct packed {
    logic [COORD_W-1:0] x_offset;
    logic [COORD_W-1:0] y_offset;
    logic [SCALE_W-1:0] x_scale_recip;
    logic [SCALE_W-1:0] y_scale_recip;
    logic [COORD_W-1:0] x_limit;
    logic [COORD_W-1:0] y_limit;
  } cfg_t;

  // one assembled report, raw coordinates
  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
  } report_t;

  // stage load strobes shared by both calibration lanes
  typedef struct packed {
    logic prod_load;
    logic out_load;
  } pipe_ctrl_t;

endpackage

// ===== design/touch_report_parser.sv =====
// touch report parser top level: framer, two calibration lanes, output stage
// one byte accepted per cycle while in_ready is high; a point becomes valid after its last
// byte is taken, through the report, product and result registers; the single multiply per lane
// sets the stage split; stalls on out_ready propagate back only to closing bytes
// synchronous reset clears phase, valid flags and restores calibration registers
// depends on trp_pkg, trp_cfg, trp_frame, trp_calib
module touch_report_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trp_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_press,
  output logic [trp_pkg::COORD_W-1:0]   x_pos,
  output logic [trp_pkg::COORD_W-1:0]   y_pos,
  input  logic                          cfg_wr_en,
  input  logic [trp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import trp_pkg::*;

  cfg_t       cfg;
  report_t    rpt;
  pipe_ctrl_t ctrl;
  logic       rpt_valid;
  logic       prod_valid;
  logic       prod_kind;
  logic       out_room;
  logic       prod_room;

  trp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trp_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .down_ready (prod_room),
    .rpt_valid  (rpt_valid),
    .rpt        (rpt)
  );

  // stage advance: each stage moves when the next is empty or draining
  assign out_room       = !out_valid || out_ready;
  assign prod_room      = !prod_valid || out_room;
  assign ctrl.prod_load = rpt_valid && prod_room;
  assign ctrl.out_load  = prod_valid && out_room;

  trp_calib u_calib_x (
    .clk    (clk),
    .ctrl   (ctrl),
    .raw    (rpt.raw_x),
    .offset (cfg.x_offset),
    .recip  (cfg.x_scale_recip),
    .limit  (cfg.x_limit),
    .pos    (x_pos)
  );

  trp_calib u_calib_y (
    .clk    (clk),
    .ctrl   (ctrl),
    .raw    (rpt.raw_y),
    .offset (cfg.y_offset),
    .recip  (cfg.y_scale_recip),
    .limit  (cfg.y_limit),
    .pos    (y_pos)
  );

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_room) begin
        prod_valid <= rpt_valid;
      end
      if (out_room) begin
        out_valid <= prod_valid;
      end
    end
  end

  // report kind follows the lanes
  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      prod_kind <= rpt.kind;
    end
    if (ctrl.out_load) begin
      is_press <= prod_kind;
    end
  end

endmodule

// ===== design/trp_cfg.sv =====
// calibration register file of the touch report parser
// depends on trp_pkg
module trp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [trp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output trp_pkg::cfg_t                     cfg
);
  import trp_pkg::*;

  // register writes, bits beyond each width dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_offset      <= RST_X_OFFSET;
      cfg.y_offset      <= RST_Y_OFFSET;
      cfg.x_scale_recip <= RST_X_RECIP;
      cfg.y_scale_recip <= RST_Y_RECIP;
      cfg.x_limit       <= RST_X_LIMIT;
      cfg.y_limit       <= RST_Y_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_X_OFFSET: cfg.x_offset      <= cfg_data[COORD_W-1:0];
        CFG_Y_OFFSET: cfg.y_offset      <= cfg_data[COORD_W-1:0];
        CFG_X_RECIP:  cfg.x_scale_recip <= cfg_data[SCALE_W-1:0];
        CFG_Y_RECIP:  cfg.y_scale_recip <= cfg_data[SCALE_W-1:0];
        CFG_X_LIMIT:  cfg.x_limit       <= cfg_data[COORD_W-1:0];
        CFG_Y_LIMIT:  cfg.y_limit       <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/trp_frame.sv =====
// byte framer: header detection and report assembly into a register
// depends on trp_pkg
module trp_frame (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trp_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          down_ready,
  output logic                          rpt_valid,
  output trp_pkg::report_t              rpt
);
  import trp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_XLO  = 3'd1,
    PH_XHI  = 3'd2,
    PH_YLO  = 3'd3,
    PH_YHI  = 3'd4
  } phase_t;

  phase_t              phase;
  logic                report_kind;
  logic [LOW_W-1:0]    x_low_bits;
  logic [HIGH_W-1:0]   x_high_bits;
  logic [LOW_W-1:0]    y_low_bits;
  logic                accept;

  // only the closing byte needs room in the report register
  assign in_ready = (phase != PH_YHI) || !rpt_valid || down_ready;
  assign accept   = in_valid && in_ready;

  // phase sequencer and report register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      report_kind <= 1'b0;
      x_low_bits  <= '0;
      x_high_bits <= '0;
      y_low_bits  <= '0;
      rpt_valid   <= 1'b0;
    end else begin
      if (accept && phase == PH_YHI) begin
        rpt_valid <= 1'b1;
      end else if (down_ready) begin
        rpt_valid <= 1'b0;
      end
      if (accept) begin
        case (phase)
          PH_XLO: begin
            x_low_bits <= rx_byte[LOW_W-1:0];
            phase      <= PH_XHI;
          end
          PH_XHI: begin
            x_high_bits <= rx_byte[HIGH_W-1:0];
            phase       <= PH_YLO;
          end
          PH_YLO: begin
            y_low_bits <= rx_byte[LOW_W-1:0];
            phase      <= PH_YHI;
          end
          PH_YHI: begin
            rpt.kind  <= report_kind;
            rpt.raw_x <= {x_high_bits, x_low_bits};
            rpt.raw_y <= {rx_byte[HIGH_W-1:0], y_low_bits};
            phase     <= PH_IDLE;
          end
          default: begin
            // idle, also any unused phase code
            phase <= PH_IDLE;
            if (rx_byte == HDR_PRESS) begin
              report_kind <= 1'b1;
              phase       <= PH_XLO;
            end else if (rx_byte == HDR_RELEASE) begin
              report_kind <= 1'b0;
              phase       <= PH_XLO;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== design/trp_calib.sv =====
// one calibration lane: offset, clamp at zero, scale multiply, limit clamp
// depends on trp_pkg
module trp_calib (
  input  logic                          clk,
  input  trp_pkg::pipe_ctrl_t           ctrl,
  input  logic [trp_pkg::COORD_W-1:0]   raw,
  input  logic [trp_pkg::COORD_W-1:0]   offset,
  input  logic [trp_pkg::SCALE_W-1:0]   recip,
  input  logic [trp_pkg::COORD_W-1:0]   limit,
  output logic [trp_pkg::COORD_W-1:0]   pos
);
  import trp_pkg::*;

  logic [COORD_W-1:0] diff;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  prod_next;
  logic [COORD_W-1:0] scaled;
  logic [COORD_W-1:0] pos_next;

  // offset removal clamped at zero, then the scale product
  assign diff      = (raw > offset) ? (raw - offset) : '0;
  assign prod_next = {{SCALE_W{1'b0}}, diff} * {{COORD_W{1'b0}}, recip};

  // drop the 16 fraction bits and clamp to the limit
  assign scaled   = prod[PROD_W-1 -: COORD_W];
  assign pos_next = (scaled > limit) ? limit : scaled;

  // product and result registers
  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      prod <= prod_next;
    end
    if (ctrl.out_load) begin
      pos <= pos_next;
    end
  end

endmodule

// ===== design/trp_checker.sv =====
// port-level checks for the touch report parser, bound to the top level
// depends on trp_pkg and touch_report_parser_defines.svh
`include "touch_report_parser_defines.svh"

module trp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           is_press,
  input logic [trp_pkg::COORD_W-1:0]    x_pos,
  input logic [trp_pkg::COORD_W-1:0]    y_pos
);
  import trp_pkg::*;

  // reset empties the result stage
  `TRP_ASSERT_ALWAYS(a_reset_clears, clk, rst, !out_valid)

  // input only stalls behind a blocked result
  `TRP_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready)

  // a fresh point implies a byte was taken earlier
  `TRP_ASSERT_NOW(a_rise_latency, clk, rst, $rose(out_valid),
    $past(in_valid && in_ready, 3))

  // held result keeps its payload
  `TRP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(is_press) && $stable(x_pos) && $stable(y_pos))

endmodule

bind touch_report_parser trp_checker u_trp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .is_press  (is_press),
  .x_pos     (x_pos),
  .y_pos     (y_pos)
);

// ===== bench/tb_touch_report_parser.sv =====
`timescale 1ns / 1ps
// self-checking bench for touch_report_parser: directed rows, then random reports
// depends on trp_pkg and touch_report_parser; predicts points with its own parser copy
module tb_touch_report_parser;
  import trp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_PAD      = 8;
  localparam int DIR_ROWS       = 24;
  localparam int PHASE_ITEMS    = 105;
  localparam int NUM_SETTINGS   = 5;

  // indexes past the last register, ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

  typedef enum logic [2:0] {WAIT_HDR, WAIT_XL, WAIT_XH, WAIT_YL, WAIT_YH} frame_phase_t;

  typedef struct packed {
    logic               press;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pinned;
    point_t            pt;
  } stim_row_t;

  localparam point_t NO_POINT = '0;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic                  is_press;
  logic [COORD_W-1:0]    x_pos;
  logic [COORD_W-1:0]    y_pos;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // typed-in expectation that rides along with a directed byte
  logic   pin_valid;
  point_t pin_pt;

  // predictor state and calibration copy
  frame_phase_t       frm_phase;
  logic               frm_kind;
  logic [LOW_W-1:0]   frm_xl;
  logic [HIGH_W-1:0]  frm_xh;
  logic [LOW_W-1:0]   frm_yl;
  cfg_t               cal_regs;

  point_t pending_points [$];
  int     errors;
  int     bytes_taken;
  int     points_checked;
  int     idle_cycles;
  int     settings_run;
  bit     hold_req;
  bit     send_calm;

  // directed requests; typed-in points use the reset calibration
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b0, NO_POINT},
    '{8'h7F, 1'b0, NO_POINT},
    '{8'h82, 1'b0, NO_POINT},
    '{8'hFF, 1'b0, NO_POINT},
    // all-zero raw coordinates sit below both offsets
    '{HDR_PRESS, 1'b0, NO_POINT},
    '{8'h00, 1'b0, NO_POINT},
    '{8'h00, 1'b0, NO_POINT},
    '{8'h00, 1'b0, NO_POINT},
    '{8'h00, 1'b1, '{1'b1, 12'd0, 12'd0}},
    // full-scale raw coordinates clamp at the limits
    '{HDR_RELEASE, 1'b0, NO_POINT},
    '{8'h7F, 1'b0, NO_POINT},
    '{8'h1F, 1'b0, NO_POINT},
    '{8'h7F, 1'b0, NO_POINT},
    '{8'h1F, 1'b1, '{1'b0, RST_X_LIMIT, RST_Y_LIMIT}},
    // header values inside a report are plain data
    '{HDR_PRESS, 1'b0, NO_POINT},
    '{HDR_PRESS, 1'b0, NO_POINT},
    '{HDR_RELEASE, 1'b0, NO_POINT},
    '{HDR_PRESS, 1'b0, NO_POINT},
    '{HDR_RELEASE, 1'b1, '{1'b1, 12'd0, 12'd0}},
    // mid-range point
    '{HDR_RELEASE, 1'b0, NO_POINT},
    '{8'h40, 1'b0, NO_POINT},
    '{8'h0A, 1'b0, NO_POINT},
    '{8'h33, 1'b0, NO_POINT},
    '{8'h05, 1'b0, NO_POINT}
  };

  touch_report_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_press  (is_press),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offset, scale and clamp of one raw coordinate
  function automatic logic [COORD_W-1:0] calibrated_coord(
    input logic [COORD_W-1:0] raw,
    input logic [COORD_W-1:0] offset,
    input logic [SCALE_W-1:0] recip,
    input logic [COORD_W-1:0] limit
  );
    logic [COORD_W-1:0] diff;
    logic [PROD_W-1:0]  prod;
    logic [COORD_W-1:0] val;
    diff = (raw > offset) ? raw - offset : '0;
    prod = diff * recip;
    val  = prod[PROD_W-1:SCALE_W];
    if (val > limit) val = limit;
    return val;
  endfunction

  // advance the report framer by one byte
  task automatic frame_byte(input logic [BYTE_W-1:0] b, output logic done,
                            output point_t pt);
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    done = 1'b0;
    pt   = NO_POINT;
    case (frm_phase)
      WAIT_XL: begin
        frm_xl    = b[LOW_W-1:0];
        frm_phase = WAIT_XH;
      end
      WAIT_XH: begin
        frm_xh    = b[HIGH_W-1:0];
        frm_phase = WAIT_YL;
      end
      WAIT_YL: begin
        frm_yl    = b[LOW_W-1:0];
        frm_phase = WAIT_YH;
      end
      WAIT_YH: begin
        raw_x     = {frm_xh, frm_xl};
        raw_y     = {b[HIGH_W-1:0], frm_yl};
        pt.press  = frm_kind;
        pt.x      = calibrated_coord(raw_x, cal_regs.x_offset, cal_regs.x_scale_recip,
                                     cal_regs.x_limit);
        pt.y      = calibrated_coord(raw_y, cal_regs.y_offset, cal_regs.y_scale_recip,
                                     cal_regs.y_limit);
        done      = 1'b1;
        frm_phase = WAIT_HDR;
      end
      default: begin
        frm_phase = WAIT_HDR;
        if (b == HDR_PRESS) begin
          frm_kind  = 1'b1;
          frm_phase = WAIT_XL;
        end else if (b == HDR_RELEASE) begin
          frm_kind  = 1'b0;
          frm_phase = WAIT_XL;
        end
      end
    endcase
  endtask

  // predict on accepted bytes, check accepted points, watch for a hang
  always @(posedge clk) begin : scoreboard
    logic   done;
    point_t pt;
    point_t want;
    if (rst) begin
      frm_phase   = WAIT_HDR;
      frm_kind    = 1'b0;
      frm_xl      = '0;
      frm_xh      = '0;
      frm_yl      = '0;
      cal_regs    = '{RST_X_OFFSET, RST_Y_OFFSET, RST_X_RECIP, RST_Y_RECIP,
                      RST_X_LIMIT, RST_Y_LIMIT};
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_X_OFFSET: cal_regs.x_offset      = cfg_data[COORD_W-1:0];
          CFG_Y_OFFSET: cal_regs.y_offset      = cfg_data[COORD_W-1:0];
          CFG_X_RECIP:  cal_regs.x_scale_recip = cfg_data[SCALE_W-1:0];
          CFG_Y_RECIP:  cal_regs.y_scale_recip = cfg_data[SCALE_W-1:0];
          CFG_X_LIMIT:  cal_regs.x_limit       = cfg_data[COORD_W-1:0];
          CFG_Y_LIMIT:  cal_regs.y_limit       = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        frame_byte(rx_byte, done, pt);
        if (done) pending_points.push_back(pin_valid ? pin_pt : pt);
        bytes_taken = bytes_taken + 1;
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (pending_points.size() == 0) begin
          $display("%0t: point with none expected: is_press %0d x %0d y %0d",
                   $time, is_press, x_pos, y_pos);
          errors = errors + 1;
        end else begin
          want = pending_points.pop_front();
          points_checked = points_checked + 1;
          if (is_press !== want.press) begin
            $display("%0t: is_press expected %0d got %0d", $time, want.press, is_press);
            errors = errors + 1;
          end
          if (x_pos !== want.x) begin
            $display("%0t: x_pos expected %0d got %0d", $time, want.x, x_pos);
            errors = errors + 1;
          end
          if (y_pos !== want.y) begin
            $display("%0t: y_pos expected %0d got %0d", $time, want.y, y_pos);
            errors = errors + 1;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
        $display("touch_report_parser test failed");
        $finish;
      end
    end
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // point receiver: random stalls, calm stretches, one long hold-off on request
  initial begin : receiver
    int stall;
    int calm_left;
    out_ready = 1'b0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left = calm_left - 1;
        out_ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 80);
        stall = pick_pause();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // offer one byte and hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic pinned, input point_t pt);
    int gap;
    gap = send_calm ? 0 : pick_pause();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    rx_byte   <= b;
    pin_valid <= pinned;
    pin_pt    <= pt;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every expected point
  task automatic drain(input bit pad);
    @(negedge clk);
    in_valid  <= 1'b0;
    pin_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    if (pad) repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one calibration setting per phase, extremes included
  task automatic configure(input int ph);
    case (ph)
      0: begin
        write_reg(CFG_X_OFFSET, CFG_DATA_W'($urandom));
        write_reg(CFG_Y_OFFSET, CFG_DATA_W'($urandom));
        write_reg(CFG_X_RECIP, CFG_DATA_W'($urandom));
        write_reg(CFG_Y_RECIP, CFG_DATA_W'($urandom));
        write_reg(CFG_X_LIMIT, CFG_DATA_W'($urandom));
        write_reg(CFG_Y_LIMIT, CFG_DATA_W'($urandom));
        write_reg(CFG_UNMAPPED_A, CFG_DATA_W'($urandom));
        write_reg(CFG_UNMAPPED_B, CFG_DATA_W'($urandom));
      end
      1: begin
        // upper data bits set but dropped: zero offsets, widest scale and limits
        write_reg(CFG_X_OFFSET, 16'hF000);
        write_reg(CFG_Y_OFFSET, 16'hF000);
        write_reg(CFG_X_RECIP, 16'hFFFF);
        write_reg(CFG_Y_RECIP, 16'hFFFF);
        write_reg(CFG_X_LIMIT, 16'hFFFF);
        write_reg(CFG_Y_LIMIT, 16'hFFFF);
      end
      2: begin
        write_reg(CFG_X_OFFSET, 16'h0FFF);
        write_reg(CFG_Y_OFFSET, 16'h0FFF);
        write_reg(CFG_X_RECIP, 16'h0000);
        write_reg(CFG_Y_RECIP, 16'h0000);
        write_reg(CFG_X_LIMIT, 16'h0000);
        write_reg(CFG_Y_LIMIT, 16'h0000);
      end
      3: begin
        // small limits so most points clamp
        write_reg(CFG_X_OFFSET, 16'h0000);
        write_reg(CFG_Y_OFFSET, 16'h0000);
        write_reg(CFG_X_RECIP, CFG_DATA_W'($urandom));
        write_reg(CFG_Y_RECIP, CFG_DATA_W'($urandom));
        write_reg(CFG_X_LIMIT, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(CFG_Y_LIMIT, CFG_DATA_W'($urandom_range(0, 255)));
      end
      default: begin
        write_reg(CFG_X_OFFSET, CFG_DATA_W'($urandom));
        write_reg(CFG_Y_OFFSET, CFG_DATA_W'($urandom));
        write_reg(CFG_X_RECIP, 16'hFFFF);
        write_reg(CFG_Y_RECIP, 16'hFFFF);
        write_reg(CFG_X_LIMIT, 16'h0FFF);
        write_reg(CFG_Y_LIMIT, 16'h0FFF);
      end
    endcase
    settings_run = settings_run + 1;
  endtask

  // mostly whole reports, some cut short, some idle noise
  task automatic random_traffic(input int n_items, input bit hold_first, input bit pause_mid);
    int                 sent;
    int                 r;
    int                 cut;
    int                 k;
    bit                 paused;
    logic [BYTE_W-1:0]  pkt [5];
    logic [COORD_W-1:0] rx_t;
    logic [COORD_W-1:0] ry_t;
    sent   = 0;
    paused = 1'b0;
    if (hold_first) hold_req = 1'b1;
    while (sent < n_items) begin
      if ($urandom_range(0, 11) == 0) send_calm = !send_calm;
      if (pause_mid && !paused && sent >= n_items / 2) begin
        drain(1'b0);
        paused = 1'b1;
      end
      pkt[0] = $urandom_range(0, 1) ? HDR_PRESS : HDR_RELEASE;
      for (k = 1; k < 5; k++) pkt[k] = BYTE_W'($urandom);
      // raw values around the offsets, where the zero clamp switches
      if ($urandom_range(0, 3) == 0) begin
        rx_t = COORD_W'(cal_regs.x_offset + $urandom_range(0, 4) - 2);
        ry_t = COORD_W'(cal_regs.y_offset + $urandom_range(0, 4) - 2);
        pkt[1][LOW_W-1:0]  = rx_t[LOW_W-1:0];
        pkt[2][HIGH_W-1:0] = rx_t[COORD_W-1:LOW_W];
        pkt[3][LOW_W-1:0]  = ry_t[LOW_W-1:0];
        pkt[4][HIGH_W-1:0] = ry_t[COORD_W-1:LOW_W];
      end
      r = $urandom_range(0, 99);
      if (r < 82) begin
        cut = 5;
      end else if (r < 90) begin
        cut = $urandom_range(2, 4);
      end else begin
        cut = 0;
        r   = $urandom_range(1, 3);
        for (k = 0; k < r; k++) send_byte(BYTE_W'($urandom), 1'b0, NO_POINT);
        sent = sent + r;
      end
      for (k = 0; k < cut; k++) send_byte(pkt[k], 1'b0, NO_POINT);
      sent = sent + cut;
    end
  endtask

  initial begin : stimulus
    int i;
    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_byte        = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pin_valid      = 1'b0;
    pin_pt         = NO_POINT;
    errors         = 0;
    bytes_taken    = 0;
    points_checked = 0;
    settings_run   = 1;
    hold_req       = 1'b0;
    send_calm      = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed rows at reset calibration
    for (i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].data, dir_rows[i].pinned, dir_rows[i].pt);
    drain(1'b1);

    // random reports, one calibration setting per phase
    for (i = 0; i < NUM_SETTINGS; i++) begin
      configure(i);
      random_traffic(PHASE_ITEMS, i == 0, i == 3);
      drain(1'b1);
    end

    $display("took %0d bytes, checked %0d points over %0d calibration settings",
             bytes_taken, points_checked, settings_run);
    $display("included a long output hold-off and a full drain pause mid-stream");
    if (errors == 0) begin
      $display("touch_report_parser test passed");
    end else begin
      $display("touch_report_parser test failed");
    end
    $finish;
  end

endmodule

// ===== touch_report_parser.f =====
+incdir+design
design/trp_pkg.sv
design/trp_cfg.sv
design/trp_frame.sv
design/trp_calib.sv
design/touch_report_parser.sv
design/trp_checker.sv
bench/tb_touch_report_parser.sv
